@@ sv/rtla_pkg.sv @@
// Package: shared types, command codes and sizes for the rain tip lockout accumulator.
`timescale 1ns / 1ps
package rtla_pkg;

   localparam int HISTORY_DEPTH = 6;
   localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int HIST_VAL_W = 16;
   localparam int RING_SUM_W = $clog2(HISTORY_DEPTH * ((1 << HIST_VAL_W) - 1) + 1);
   localparam int HOURLY_W = 19;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TELEM_MAX = 2'd1;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [7:0] TELEM_MAX_RESET = 8'd255;

   localparam logic [2:0] CMD_TIP = 3'd0;
   localparam logic [2:0] CMD_CLOSE = 3'd1;
   localparam logic [2:0] CMD_PUSH = 3'd2;
   localparam logic [2:0] CMD_CLR_DAILY = 3'd3;
   localparam logic [2:0] CMD_CLR_ALL = 3'd4;
   localparam logic [2:0] CMD_CLR_DIAG = 3'd5;
   localparam logic [2:0] CMD_QUERY = 3'd6;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] tick_ms;
      logic [15:0] history_value;
   } req_type;

   typedef struct packed {
      logic [15:0]         interval_count;
      logic [HOURLY_W-1:0] hourly_count;
      logic [31:0]         daily_count;
      logic [31:0]         total_tips;
      logic [7:0]          telemetry_code;
      logic                rain_active;
      logic [31:0]         rejected_count;
      logic [31:0]         last_tip_time;
      logic                tip_accepted;
   } rsp_type;

   typedef struct packed {
      logic                  push;
      logic                  clear;
      logic [HIST_VAL_W-1:0] value;
   } hist_ctrl_type;

endpackage

@@ sv/rtla_history.sv @@
// History ring of interval counts with a running sum of its entries.
`timescale 1ns / 1ps
module rtla_history (
   input  logic                           clock,
   input  logic                           reset,
   input  rtla_pkg::hist_ctrl_type        ctrl,
   output logic [rtla_pkg::RING_SUM_W-1:0] sum_next
);
   import rtla_pkg::*;

   logic [HIST_VAL_W-1:0] ring_ff [HISTORY_DEPTH];
   logic [PTR_W-1:0]      ptr_ff;
   logic [PTR_W-1:0]      ptr_in;
   logic [RING_SUM_W-1:0] sum_ff;
   logic [RING_SUM_W-1:0] sum_in;
   logic [HIST_VAL_W-1:0] old_entry;

   assign old_entry = ring_ff[ptr_ff];

   always_comb begin
      sum_in = sum_ff;
      ptr_in = ptr_ff;
      if (ctrl.clear) begin
         sum_in = '0;
         ptr_in = '0;
      end else if (ctrl.push) begin
         sum_in = sum_ff - RING_SUM_W'(old_entry) + RING_SUM_W'(ctrl.value);
         ptr_in = (ptr_ff == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_ff + PTR_W'(1);
      end
   end

   assign sum_next = sum_in;

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (ctrl.push) begin
         ring_ff[ptr_ff] <= ctrl.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         sum_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
         sum_ff <= sum_in;
      end
   end

endmodule

@@ sv/rain_tip_lockout_accumulator_core.sv @@
// Top level: rain gauge tip counter with lockout filter, accumulators and history ring.
//
//   channel   direction  ports                              beat
//   req       in         req_valid/req_ready/req_data       one command
//   rsp       out        rsp_valid/rsp_ready/rsp_data       one status record
//   csr       in         csr_we/csr_index/csr_wdata         one register write
//
// One command per cycle unless rsp stalls; its record is in rsp_ff the cycle after.
// All state updates in the accept cycle; the rate is set by the single output register.
// req_ready is high outside reset when the output register is empty or being drained.
// Synchronous reset clears all counters, the ring and the CSRs to their defaults.
`timescale 1ns / 1ps
module rain_tip_lockout_accumulator_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  rtla_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rtla_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [rtla_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rtla_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rtla_pkg::*;

   logic [15:0] debounce_ff;
   logic [7:0]  telem_max_ff;

   logic [31:0] last_time_ff, last_time_in;
   logic        seen_first_ff, seen_first_in;
   logic        active_ff, active_in;
   logic [31:0] reject_ff, reject_in;
   logic [15:0] interval_ff, interval_in;
   logic [31:0] day_ff, day_in;
   logic [31:0] life_ff, life_in;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic        accept;
   logic        tip_ok;
   logic [31:0] tick_delta;
   logic [15:0] shown;
   logic [RING_SUM_W-1:0] ring_sum;
   logic [RING_SUM_W:0]   hourly_wide;
   hist_ctrl_type         hist_ctrl;

   assign req_ready = (!rsp_valid_ff || rsp_ready) && !reset;
   assign accept = req_valid && req_ready;

   assign tick_delta = req_data.tick_ms - last_time_ff;
   assign tip_ok = !seen_first_ff || (tick_delta >= {16'd0, debounce_ff});

   assign hist_ctrl.push = accept && (req_data.cmd == CMD_PUSH);
   assign hist_ctrl.clear = accept && (req_data.cmd == CMD_CLR_ALL);
   assign hist_ctrl.value = req_data.history_value;

   rtla_history u_history (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (hist_ctrl),
      .sum_next (ring_sum)
   );

   always_comb begin
      last_time_in = last_time_ff;
      seen_first_in = seen_first_ff;
      active_in = active_ff;
      reject_in = reject_ff;
      interval_in = interval_ff;
      day_in = day_ff;
      life_in = life_ff;
      case (req_data.cmd)
         CMD_TIP: begin
            if (tip_ok) begin
               last_time_in = req_data.tick_ms;
               seen_first_in = 1'b1;
               active_in = 1'b1;
               if (interval_ff != 16'hFFFF) interval_in = interval_ff + 16'd1;
               if (day_ff != 32'hFFFF_FFFF) day_in = day_ff + 32'd1;
               if (life_ff != 32'hFFFF_FFFF) life_in = life_ff + 32'd1;
            end else begin
               reject_in = reject_ff + 32'd1;
            end
         end
         CMD_CLR_DAILY: begin
            day_in = '0;
         end
         CMD_CLR_ALL: begin
            interval_in = '0;
            day_in = '0;
            life_in = '0;
         end
         CMD_CLR_DIAG: begin
            reject_in = '0;
            active_in = 1'b0;
         end
         default: begin
         end
      endcase

      shown = interval_in;
      if (req_data.cmd == CMD_CLOSE) interval_in = '0;

      // hourly total reflects the interval after a close
      hourly_wide = (RING_SUM_W + 1)'(ring_sum) + (RING_SUM_W + 1)'(interval_in);

      rsp_in.interval_count = shown;
      rsp_in.hourly_count = (hourly_wide > (RING_SUM_W + 1)'((1 << HOURLY_W) - 1)) ?
                            {HOURLY_W{1'b1}} : HOURLY_W'(hourly_wide);
      rsp_in.daily_count = day_in;
      rsp_in.total_tips = life_in;
      rsp_in.telemetry_code = (shown >= {8'd0, telem_max_ff}) ? telem_max_ff : shown[7:0];
      rsp_in.rain_active = active_in;
      rsp_in.rejected_count = reject_in;
      rsp_in.last_tip_time = last_time_in;
      rsp_in.tip_accepted = (req_data.cmd == CMD_TIP) && tip_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         telem_max_ff <= TELEM_MAX_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE:  debounce_ff <= csr_wdata;
            CSR_TELEM_MAX: telem_max_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         seen_first_ff <= 1'b0;
         active_ff <= 1'b0;
         reject_ff <= '0;
         interval_ff <= '0;
         day_ff <= '0;
         life_ff <= '0;
      end else if (accept) begin
         last_time_ff <= last_time_in;
         seen_first_ff <= seen_first_in;
         active_ff <= active_in;
         reject_ff <= reject_in;
         interval_ff <= interval_in;
         day_ff <= day_in;
         life_ff <= life_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

@@ sv/rtla_checker.sv @@
// Port-level checks for the rain tip lockout accumulator, bound to the top level.
`timescale 1ns / 1ps
module rtla_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rtla_pkg::rsp_type rsp_data
);
   import rtla_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted req beat gave no rsp beat");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_tip_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.tip_accepted |->
         rsp_data.rain_active && (rsp_data.total_tips != 32'd0)
         && (rsp_data.interval_count != 16'd0))
      else $error("accepted tip not reflected in counters");

   a_telem_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {8'd0, rsp_data.telemetry_code} <= rsp_data.interval_count)
      else $error("telemetry code above interval count");

endmodule

bind rain_tip_lockout_accumulator_core rtla_checker u_rtla_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ test/rain_tip_lockout_accumulator_core_tb.sv @@
// Testbench: self-checking regression of the rain tip lockout accumulator core.
`timescale 1ns / 1ps
module rain_tip_lockout_accumulator_core_tb;
   import rtla_pkg::*;

   localparam logic [2:0] CMD_UNUSED = 3'd7;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam int unsigned HOURLY_CEIL = (1 << HOURLY_W) - 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 30;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // gauge state as predicted
   logic [31:0] gauge_last_tick;
   logic        gauge_seen_tip;
   logic        gauge_active;
   logic [31:0] gauge_rejects;
   logic [15:0] gauge_interval;
   logic [31:0] gauge_daily;
   logic [31:0] gauge_lifetime;
   logic [15:0] gauge_ring [HISTORY_DEPTH];
   int unsigned gauge_ring_wr;
   logic [15:0] cfg_debounce;
   logic [7:0]  cfg_telem_max;

   rsp_type pending_status_q[$];
   int error_count = 0;
   int beats_checked = 0;
   int cycle_count = 0;
   int hold_len = 0;
   bit quiet_mode = 1'b0;

   rain_tip_lockout_accumulator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_REPORTS) $display("MISMATCH: %s", msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("beat %0d %s got %0h want %0h",
                                   beats_checked, name, got, want));
   endtask

   function automatic void clear_gauge();
      gauge_last_tick = '0;
      gauge_seen_tip = 1'b0;
      gauge_active = 1'b0;
      gauge_rejects = '0;
      gauge_interval = '0;
      gauge_daily = '0;
      gauge_lifetime = '0;
      foreach (gauge_ring[k]) gauge_ring[k] = '0;
      gauge_ring_wr = 0;
      cfg_debounce = DEBOUNCE_RESET;
      cfg_telem_max = TELEM_MAX_RESET;
   endfunction

   function automatic rsp_type predict_status(input req_type item);
      rsp_type st;
      logic [31:0] gap;
      logic [15:0] shown;
      int unsigned hsum;
      logic accepted;
      accepted = 1'b0;
      gap = item.tick_ms - gauge_last_tick;
      case (item.cmd)
         CMD_TIP: begin
            if (!gauge_seen_tip || gap >= 32'(cfg_debounce)) begin
               accepted = 1'b1;
               gauge_last_tick = item.tick_ms;
               gauge_active = 1'b1;
               gauge_seen_tip = 1'b1;
               if (gauge_interval != 16'hFFFF) gauge_interval++;
               if (gauge_daily != 32'hFFFF_FFFF) gauge_daily++;
               if (gauge_lifetime != 32'hFFFF_FFFF) gauge_lifetime++;
            end else begin
               gauge_rejects++;
            end
         end
         CMD_PUSH: begin
            gauge_ring[gauge_ring_wr] = item.history_value;
            gauge_ring_wr = (gauge_ring_wr + 1) % HISTORY_DEPTH;
         end
         CMD_CLR_DAILY: gauge_daily = '0;
         CMD_CLR_ALL: begin
            gauge_interval = '0;
            gauge_daily = '0;
            gauge_lifetime = '0;
            foreach (gauge_ring[k]) gauge_ring[k] = '0;
            gauge_ring_wr = 0;
         end
         CMD_CLR_DIAG: begin
            gauge_rejects = '0;
            gauge_active = 1'b0;
         end
         default: ;
      endcase
      shown = gauge_interval;
      if (item.cmd == CMD_CLOSE) gauge_interval = '0;
      hsum = 32'(gauge_interval);
      foreach (gauge_ring[k]) hsum += 32'(gauge_ring[k]);
      if (hsum > HOURLY_CEIL) hsum = HOURLY_CEIL;
      st.interval_count = shown;
      st.hourly_count = hsum[HOURLY_W-1:0];
      st.daily_count = gauge_daily;
      st.total_tips = gauge_lifetime;
      st.telemetry_code = (shown >= 16'(cfg_telem_max)) ? cfg_telem_max : shown[7:0];
      st.rain_active = gauge_active;
      st.rejected_count = gauge_rejects;
      st.last_tip_time = gauge_last_tick;
      st.tip_accepted = accepted;
      return st;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_status_q.size() == 0) begin
            report_mismatch($sformatf("beat %0d arrived with no command pending",
                                      beats_checked));
         end else begin
            want = pending_status_q.pop_front();
            check_field("interval_count", 32'(rsp_data.interval_count),
                        32'(want.interval_count));
            check_field("hourly_count", 32'(rsp_data.hourly_count),
                        32'(want.hourly_count));
            check_field("daily_count", rsp_data.daily_count, want.daily_count);
            check_field("total_tips", rsp_data.total_tips, want.total_tips);
            check_field("telemetry_code", 32'(rsp_data.telemetry_code),
                        32'(want.telemetry_code));
            check_field("rain_active", 32'(rsp_data.rain_active), 32'(want.rain_active));
            check_field("rejected_count", rsp_data.rejected_count, want.rejected_count);
            check_field("last_tip_time", rsp_data.last_tip_time, want.last_tip_time);
            check_field("tip_accepted", 32'(rsp_data.tip_accepted),
                        32'(want.tip_accepted));
         end
         beats_checked++;
      end
   end

   // receiver: random stalls, or a long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_len > 0) begin
            rsp_ready = 1'b0;
            repeat (hold_len) @(negedge clock);
            hold_len = 0;
         end
         rsp_ready = quiet_mode || ($urandom_range(0, 99) >= 12);
      end
   end

   task automatic send_item(input req_type item);
      if (!quiet_mode)
         while ($urandom_range(0, 99) < 12) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
      req_valid = 1'b1;
      req_data = item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_status_q.push_back(predict_status(item));
      @(negedge clock);
   endtask

   task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] tick,
                           input logic [15:0] hval);
      req_type item;
      item.cmd = cmd;
      item.tick_ms = tick;
      item.history_value = hval;
      send_item(item);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending_status_q.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (index)
         CSR_DEBOUNCE: cfg_debounce = value;
         CSR_TELEM_MAX: cfg_telem_max = value[7:0];
         default: ;
      endcase
   endtask

   function automatic logic [31:0] next_tip_tick();
      int unsigned pick;
      logic [31:0] span;
      pick = $urandom_range(0, 99);
      span = 32'(cfg_debounce);
      if (pick < 40) return gauge_last_tick + span + $urandom_range(0, 40);
      else if (pick < 70) return gauge_last_tick + $urandom_range(0, span);
      else if (pick < 85) return gauge_last_tick + span - $urandom_range(0, 1);
      else return $urandom;
   endfunction

   function automatic req_type random_command();
      req_type item;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      item.tick_ms = $urandom;
      item.history_value = 16'($urandom);
      if (pick < 64) begin
         item.cmd = CMD_TIP;
         item.tick_ms = next_tip_tick();
      end else if (pick < 72) item.cmd = CMD_CLOSE;
      else if (pick < 80) item.cmd = CMD_PUSH;
      else if (pick < 84) item.cmd = CMD_CLR_DAILY;
      else if (pick < 87) item.cmd = CMD_CLR_ALL;
      else if (pick < 91) item.cmd = CMD_CLR_DIAG;
      else if (pick < 97) item.cmd = CMD_QUERY;
      else item.cmd = CMD_UNUSED;
      return item;
   endfunction

   task automatic test_lockout_rules();
      send_cmd(CMD_TIP, 32'd10, 16'($urandom));          // first tip always counts
      send_cmd(CMD_TIP, 32'd40, 16'($urandom));
      send_cmd(CMD_TIP, 32'd60, 16'($urandom));          // exactly at debounce
      send_cmd(CMD_TIP, 32'hFFFF_FFFF, 16'hFFFF);
      send_cmd(CMD_TIP, 32'h0000_0020, 16'($urandom));   // wrapped, too close
      send_cmd(CMD_TIP, 32'h0000_0031, 16'($urandom));   // wrapped, just far enough
      send_cmd(CMD_QUERY, 32'd0, 16'd0);
      drain();
   endtask

   task automatic test_commands();
      send_cmd(CMD_PUSH, $urandom, 16'hFFFF);
      send_cmd(CMD_PUSH, $urandom, 16'h0000);
      send_cmd(CMD_PUSH, $urandom, 16'($urandom));
      send_cmd(CMD_CLOSE, $urandom, 16'($urandom));
      send_cmd(CMD_CLR_DAILY, $urandom, 16'($urandom));
      send_cmd(CMD_CLR_DIAG, $urandom, 16'($urandom));
      // lockout stays armed after a diagnostics clear
      send_cmd(CMD_TIP, gauge_last_tick + 1, 16'($urandom));
      send_cmd(CMD_QUERY, $urandom, 16'($urandom));
      send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
      send_cmd(CMD_CLR_ALL, $urandom, 16'($urandom));
      drain();
   endtask

   task automatic test_register_settings();
      write_register(CSR_DEBOUNCE, 16'd0);
      write_register(CSR_TELEM_MAX, 16'hAB03);      // upper byte dropped
      repeat (5) send_cmd(CMD_TIP, gauge_last_tick, 16'($urandom));
      send_cmd(CMD_CLOSE, $urandom, 16'($urandom));
      send_cmd(CMD_QUERY, $urandom, 16'($urandom));
      drain();
      write_register(CSR_TELEM_MAX, 16'd0);
      write_register(CSR_SPARE_A, 16'hFFFF);
      write_register(CSR_SPARE_B, 16'h1234);
      send_cmd(CMD_TIP, gauge_last_tick, 16'($urandom));
      drain();
      write_register(CSR_DEBOUNCE, 16'hFFFF);
      send_cmd(CMD_TIP, gauge_last_tick + 32'hFFFE, 16'($urandom));
      send_cmd(CMD_TIP, gauge_last_tick + 32'hFFFF, 16'($urandom));
      drain();
      write_register(CSR_DEBOUNCE, DEBOUNCE_RESET);
      write_register(CSR_TELEM_MAX, 16'(TELEM_MAX_RESET));
   endtask

   task automatic test_output_backpressure();
      hold_len = 80;
      repeat (16) send_item(random_command());
      drain();
   endtask

   task automatic test_telemetry_ceiling();
      quiet_mode = 1'b1;
      write_register(CSR_DEBOUNCE, 16'd0);
      write_register(CSR_TELEM_MAX, 16'd200);
      send_cmd(CMD_CLR_ALL, $urandom, 16'($urandom));
      repeat (250) send_cmd(CMD_TIP, $urandom, 16'($urandom));
      repeat (HISTORY_DEPTH) send_cmd(CMD_PUSH, $urandom, 16'hFFFF);
      send_cmd(CMD_QUERY, $urandom, 16'($urandom));
      send_cmd(CMD_CLOSE, $urandom, 16'($urandom));
      send_cmd(CMD_QUERY, $urandom, 16'($urandom));
      send_cmd(CMD_CLR_ALL, $urandom, 16'($urandom));
      drain();
      quiet_mode = 1'b0;
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_DEBOUNCE, DEBOUNCE_RESET);
               write_register(CSR_TELEM_MAX, 16'(TELEM_MAX_RESET));
            end
            1: begin
               write_register(CSR_DEBOUNCE, 16'd0);
               write_register(CSR_TELEM_MAX, 16'd0);
            end
            2: begin
               write_register(CSR_DEBOUNCE, 16'hFFFF);
               write_register(CSR_TELEM_MAX, 16'($urandom_range(1, 20)));
            end
            3: begin
               write_register(CSR_DEBOUNCE, 16'($urandom_range(1, 1000)));
               write_register(CSR_TELEM_MAX, 16'($urandom));
            end
            default: begin
               write_register(CSR_DEBOUNCE, 16'($urandom));
               write_register(CSR_TELEM_MAX, 16'hFFFF);
            end
         endcase
         quiet_mode = (phase == 3);
         repeat (70) send_item(random_command());
         drain();
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      clear_gauge();
      repeat (8) @(negedge clock);
      reset = 1'b0;
      test_lockout_rules();
      test_commands();
      test_register_settings();
      test_output_backpressure();
      test_telemetry_ceiling();
      test_random_traffic();
      drain();
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/rtla_pkg.sv
sv/rtla_history.sv
sv/rain_tip_lockout_accumulator_core.sv
sv/rtla_checker.sv
test/rain_tip_lockout_accumulator_core_tb.sv
